FILE: hw/rtl/mrmt_pkg.sv
package mrmt_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int PAGE_BYTES_DEF  = 4096;
    // slot fields in the token and command structs hold the largest table (64 entries)
    localparam int SLOT_BITS       = 6;
    localparam int MAX_LIST        = 16;
    localparam logic [19:0] PAGES_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        REQ_MAP   = 2'd0,
        REQ_UNMAP = 2'd1,
        REQ_FAULT = 2'd2,
        REQ_LIST  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_BAD_LEN   = 4'd1,
        ST_BAD_FLAGS = 4'd2,
        ST_MISALIGN  = 4'd3,
        ST_BUSY      = 4'd4,
        ST_NO_SLOT   = 4'd5,
        ST_BAD_FILE  = 4'd6,
        ST_NOT_FOUND = 4'd7,
        ST_NOT_MAPPED= 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CMD_MAP = 2'd0,
        CMD_CLR = 2'd1,
        CMD_INC = 2'd2
    } t_cmd_op;

    localparam logic CFG_WLOW  = 1'b0;
    localparam logic CFG_WHIGH = 1'b1;

    typedef struct packed {
        t_req               req_type;
        logic [31:0]        addr;
        logic signed [31:0] length;
        logic               fixed_flag;
        logic               shared_flag;
        logic               anon_flag;
        logic               file_ok;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic [31:0] region_start;
        logic [30:0] region_length;
        logic [30:0] page_offset;
        logic [19:0] loaded_pages;
        logic [4:0]  live_count;
        logic        file_backed;
        logic        need_writeback;
        logic        entry_valid;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        index;
        logic [32:0] value;
    } t_cfg;

    typedef struct packed {
        logic        live;
        logic [31:0] start;
        logic [30:0] length;
        logic        anon;
        logic        shared;
        logic [19:0] pages;
    } t_entry;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                 vld;
        t_req                 req;
        logic [31:0]          addr;
        logic [32:0]          fin;
        logic                 hit;
        logic [SLOT_BITS-1:0] hit_slot;
        logic                 free;
        logic [SLOT_BITS-1:0] free_slot;
    } t_tok;

    typedef struct packed {
        logic                 en;
        t_cmd_op              op;
        logic [SLOT_BITS-1:0] slot;
        logic [31:0]          start;
        logic [30:0]          length;
        logic                 anon;
    } t_cmd;

endpackage

FILE: hw/rtl/mrmt_cell.sv
module mrmt_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrmt_pkg::t_tok  i_tok,
    input  mrmt_pkg::t_cmd  i_cmd,
    output mrmt_pkg::t_tok  o_tok,
    output mrmt_pkg::t_entry o_ent
);
    import mrmt_pkg::*;

    t_entry      r_ent;
    t_tok        r_tok;
    t_tok        n_tok;
    logic [32:0] w_end;
    logic        w_match;

    assign w_end = {1'b0, r_ent.start} + {2'b0, r_ent.length};

    always_comb begin
        case (i_tok.req)
            REQ_MAP:   w_match = r_ent.live && ({1'b0, i_tok.addr} < w_end)
                                 && (i_tok.fin > {1'b0, r_ent.start});
            REQ_UNMAP: w_match = r_ent.live && (r_ent.start == i_tok.addr);
            REQ_FAULT: w_match = r_ent.live && (i_tok.addr >= r_ent.start)
                                 && ({1'b0, i_tok.addr} < w_end);
            default:   w_match = 1'b0;
        endcase
    end

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && w_match) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_slot = SLOT_BITS'(IDX);
        end
        if (!i_tok.free && !r_ent.live) begin
            n_tok.free      = 1'b1;
            n_tok.free_slot = SLOT_BITS'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else if (i_cmd.en && i_cmd.slot == SLOT_BITS'(IDX)) begin
            case (i_cmd.op)
                CMD_MAP: begin
                    r_ent.live   <= 1'b1;
                    r_ent.start  <= i_cmd.start;
                    r_ent.length <= i_cmd.length;
                    r_ent.anon   <= i_cmd.anon;
                    r_ent.shared <= 1'b1;
                    r_ent.pages  <= '0;
                end
                CMD_CLR: r_ent <= '0;
                CMD_INC: begin
                    if (r_ent.pages != PAGES_MAX) begin
                        r_ent.pages <= r_ent.pages + 20'd1;
                    end
                end
                default: r_ent <= r_ent;
            endcase
        end
    end

    assign o_tok = r_tok;
    assign o_ent = r_ent;
endmodule

FILE: hw/rtl/memory_region_map_table.sv
// Region table with overlap check. Each of NUM_ENTRIES cells holds one
// region; a map, unmap or fault request sends a scan token down the row of
// cells, one cell per cycle, which picks up the first matching slot and the
// first free slot. For map, unmap and fault, the token from the last cell is
// registered as the scan result, and the decision then loads the output
// register once it is free. A list request walks the slots one a cycle
// while the output register is free and gives one beat per live entry
// (at most 16, last marks the final one); an empty table gives a single beat
// with entry_valid clear. One request is in flight at a time; the output
// register lets the result wait while the block returns to idle. Window
// registers (0 low, 1 high) are written through the config channel and are
// always ready. PAGE_BYTES must be a power of two; nothing here checks it.
module memory_region_map_table #(
    parameter int NUM_ENTRIES = mrmt_pkg::NUM_ENTRIES_DEF,
    parameter int PAGE_BYTES  = mrmt_pkg::PAGE_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mrmt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mrmt_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  mrmt_pkg::t_cfg i_cfg_data
);
    import mrmt_pkg::*;

    localparam int SW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int LW = $clog2(NUM_ENTRIES + 1);
    localparam int PS = $clog2(PAGE_BYTES);
    localparam logic [32:0] PMASK = 33'(PAGE_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RESP = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_in         r_req;
    t_tok        r_scan;
    logic [31:0] r_wlow;
    logic [32:0] r_whigh;
    logic [LW-1:0] r_live, n_live;
    logic [SW-1:0] r_idx;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    t_out        r_out, n_out;
    logic        w_out_load;
    logic        w_out_free;
    logic        w_accept;

    t_tok   w_tok [NUM_ENTRIES+1];
    t_entry w_ent [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] w_live_vec;
    t_cmd   w_cmd;

    // page-rounded end of a map, no wrap
    function automatic logic [32:0] f_end(input logic [31:0] addr,
                                          input logic [31:0] len);
        logic [32:0] rnd;
        rnd = ({1'b0, len} + PMASK) & ~PMASK;
        return {1'b0, addr} + rnd;
    endfunction

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // token launch into the first cell
    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].vld       = w_accept && (i_in_data.req_type != REQ_LIST);
        w_tok[0].req       = i_in_data.req_type;
        w_tok[0].addr      = i_in_data.addr;
        w_tok[0].fin       = f_end(i_in_data.addr, i_in_data.length);
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        mrmt_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .i_cmd  (w_cmd),
            .o_tok  (w_tok[g+1]),
            .o_ent  (w_ent[g])
        );
        assign w_live_vec[g] = w_ent[g].live;
    end

    // decision and list logic
    t_entry      w_hit_ent;
    t_entry      w_lst_ent;
    logic        w_any_above;
    logic [31:0] w_page;
    logic [32:0] w_rend;
    logic        w_mis;

    assign w_hit_ent = w_ent[r_scan.hit_slot[SW-1:0]];
    assign w_lst_ent = w_ent[r_idx];
    assign w_page    = r_req.addr & ~PMASK[31:0];
    assign w_rend    = f_end(r_req.addr, r_req.length);
    assign w_mis     = (r_req.addr[PS-1:0] != '0);

    always_comb begin
        w_any_above = 1'b0;
        for (int j = 0; j < NUM_ENTRIES; j++) begin
            if (SW'(j) > r_idx && w_live_vec[j]) begin
                w_any_above = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out      = '0;
        n_live     = r_live;
        w_out_load = 1'b0;
        w_cmd      = '0;
        w_cmd.slot = r_scan.hit_slot;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.req_type == REQ_LIST) ? S_LIST : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[NUM_ENTRIES].vld) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    n_out.last = 1'b1;
                    case (r_req.req_type)
                        REQ_MAP: begin
                            if (r_req.length == '0 || r_req.length[31]) begin
                                n_out.status = ST_BAD_LEN;
                            end else if (!r_req.fixed_flag || !r_req.shared_flag) begin
                                n_out.status = ST_BAD_FLAGS;
                            end else if (w_mis) begin
                                n_out.status = ST_MISALIGN;
                            end else if (r_req.addr < r_wlow || w_rend > r_whigh
                                         || r_scan.hit) begin
                                n_out.status = ST_BUSY;
                            end else if (!r_scan.free) begin
                                n_out.status = ST_NO_SLOT;
                            end else if (!r_req.anon_flag && !r_req.file_ok) begin
                                n_out.status = ST_BAD_FILE;
                            end else begin
                                n_live              = r_live + LW'(1);
                                w_cmd.en            = 1'b1;
                                w_cmd.op            = CMD_MAP;
                                w_cmd.slot          = r_scan.free_slot;
                                w_cmd.start         = r_req.addr;
                                w_cmd.length        = r_req.length[30:0];
                                w_cmd.anon          = r_req.anon_flag;
                                n_out.status        = ST_OK;
                                n_out.slot          = 4'(r_scan.free_slot);
                                n_out.region_start  = r_req.addr;
                                n_out.region_length = r_req.length[30:0];
                                n_out.file_backed   = !r_req.anon_flag;
                            end
                        end
                        REQ_UNMAP: begin
                            if (w_mis) begin
                                n_out.status = ST_MISALIGN;
                            end else if (!r_scan.hit) begin
                                n_out.status = ST_NOT_FOUND;
                            end else begin
                                if (r_live != '0) begin
                                    n_live = r_live - LW'(1);
                                end
                                w_cmd.en             = 1'b1;
                                w_cmd.op             = CMD_CLR;
                                n_out.status         = ST_OK;
                                n_out.slot           = 4'(r_scan.hit_slot);
                                n_out.region_start   = r_req.addr;
                                n_out.region_length  = w_hit_ent.length;
                                n_out.loaded_pages   = w_hit_ent.pages;
                                n_out.file_backed    = !w_hit_ent.anon;
                                n_out.need_writeback = !w_hit_ent.anon
                                                       && w_hit_ent.shared;
                            end
                        end
                        default: begin
                            if (!r_scan.hit) begin
                                n_out.status = ST_NOT_MAPPED;
                            end else begin
                                w_cmd.en            = 1'b1;
                                w_cmd.op            = CMD_INC;
                                n_out.status        = ST_OK;
                                n_out.slot          = 4'(r_scan.hit_slot);
                                n_out.region_start  = w_hit_ent.start;
                                n_out.region_length = w_hit_ent.length;
                                n_out.page_offset   = (w_page >= w_hit_ent.start)
                                    ? 31'(w_page - w_hit_ent.start) : '0;
                                n_out.loaded_pages  = (w_hit_ent.pages != PAGES_MAX)
                                    ? w_hit_ent.pages + 20'd1 : PAGES_MAX;
                                n_out.file_backed   = !w_hit_ent.anon;
                            end
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    if (w_live_vec == '0) begin
                        w_out_load = 1'b1;
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end else if (w_lst_ent.live) begin
                        w_out_load          = 1'b1;
                        n_out.status        = ST_OK;
                        n_out.slot          = 4'(r_idx);
                        n_out.region_start  = w_lst_ent.start;
                        n_out.region_length = w_lst_ent.length;
                        n_out.loaded_pages  = w_lst_ent.pages;
                        n_out.file_backed   = !w_lst_ent.anon;
                        n_out.entry_valid   = 1'b1;
                        n_out.last          = !w_any_above
                                              || (r_cnt == 5'(MAX_LIST - 1));
                        if (n_out.last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out.live_count = 5'(n_live);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_wlow      <= 32'h6000_0000;
            r_whigh     <= 33'h0_8000_0000;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_data.index)
                    CFG_WLOW:  r_wlow  <= i_cfg_data.value[31:0];
                    CFG_WHIGH: r_whigh <= i_cfg_data.value;
                    default:   r_wlow  <= r_wlow;
                endcase
            end
            if (w_accept) begin
                r_idx <= '0;
                r_cnt <= '0;
            end else if (r_state == S_LIST && w_out_free) begin
                if (w_lst_ent.live) begin
                    r_cnt <= r_cnt + 5'd1;
                end
                if (r_idx != SW'(NUM_ENTRIES - 1)) begin
                    r_idx <= r_idx + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (w_tok[NUM_ENTRIES].vld) begin
            r_scan <= w_tok[NUM_ENTRIES];
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: tb/region_table_sb.sv
// Scoreboard for the region table: mirrors the table and window registers,
// predicts result beats per accepted request and checks them in order.
import mrmt_pkg::*;

class region_table_sb;

    localparam int NSLOT = 16;
    localparam int PAGE  = 4096;

    t_entry      tbl [NSLOT];
    logic [4:0]  live_n;
    logic [32:0] win_lo;
    logic [32:0] win_hi;
    t_out        pending [$];
    int          errors;
    int          beats_ok;
    int          n_req;
    int          n_map_ok;
    int          n_fault_ok;

    function new();
        for (int i = 0; i < NSLOT; i++) tbl[i] = '0;
        live_n     = '0;
        win_lo     = 33'h060000000;
        win_hi     = 33'h080000000;
        errors     = 0;
        beats_ok   = 0;
        n_req      = 0;
        n_map_ok   = 0;
        n_fault_ok = 0;
    endfunction

    function void write_window(logic idx, logic [32:0] val);
        if (idx == CFG_WLOW) win_lo = {1'b0, val[31:0]};
        else                 win_hi = val;
    endfunction

    function t_out err_beat(t_status st);
        t_out o;
        o            = '0;
        o.status     = st;
        o.live_count = live_n;
        o.last       = 1'b1;
        return o;
    endfunction

    function t_out entry_beat(int s);
        t_out o;
        o               = '0;
        o.status        = ST_OK;
        o.slot          = s[3:0];
        o.region_start  = tbl[s].start;
        o.region_length = tbl[s].length;
        o.loaded_pages  = tbl[s].pages;
        o.file_backed   = !tbl[s].anon;
        o.live_count    = live_n;
        return o;
    endfunction

    function void predict_map(t_in r);
        logic [32:0] rnd, fin;
        int          fs;
        t_out        o;
        fs = -1;
        if (r.length <= 0) begin
            pending.push_back(err_beat(ST_BAD_LEN)); return;
        end
        if (!r.fixed_flag || !r.shared_flag) begin
            pending.push_back(err_beat(ST_BAD_FLAGS)); return;
        end
        if (r.addr[11:0] != 0) begin
            pending.push_back(err_beat(ST_MISALIGN)); return;
        end
        rnd = ({1'b0, r.length} + PAGE - 1) & ~33'(PAGE - 1);
        fin = {1'b0, r.addr} + rnd;
        if ({1'b0, r.addr} < win_lo || fin > win_hi) begin
            pending.push_back(err_beat(ST_BUSY)); return;
        end
        for (int i = 0; i < NSLOT; i++)
            if (tbl[i].live && {1'b0, r.addr} < {1'b0, tbl[i].start} + tbl[i].length
                && fin > {1'b0, tbl[i].start}) begin
                pending.push_back(err_beat(ST_BUSY)); return;
            end
        for (int i = NSLOT - 1; i >= 0; i--) if (!tbl[i].live) fs = i;
        if (fs < 0) begin
            pending.push_back(err_beat(ST_NO_SLOT)); return;
        end
        if (!r.anon_flag && !r.file_ok) begin
            pending.push_back(err_beat(ST_BAD_FILE)); return;
        end
        tbl[fs].live   = 1'b1;
        tbl[fs].start  = r.addr;
        tbl[fs].length = r.length[30:0];
        tbl[fs].anon   = r.anon_flag;
        tbl[fs].shared = 1'b1;
        tbl[fs].pages  = '0;
        live_n++;
        n_map_ok++;
        o = entry_beat(fs);
        o.last = 1'b1;
        pending.push_back(o);
    endfunction

    function void predict_unmap(t_in r);
        t_out o;
        if (r.addr[11:0] != 0) begin
            pending.push_back(err_beat(ST_MISALIGN)); return;
        end
        for (int i = 0; i < NSLOT; i++)
            if (tbl[i].live && tbl[i].start == r.addr) begin
                if (live_n > 0) live_n--;
                o = entry_beat(i);
                o.need_writeback = !tbl[i].anon && tbl[i].shared;
                o.last           = 1'b1;
                tbl[i]           = '0;
                pending.push_back(o);
                return;
            end
        pending.push_back(err_beat(ST_NOT_FOUND));
    endfunction

    function void predict_fault(t_in r);
        t_out        o;
        logic [31:0] pg;
        for (int i = 0; i < NSLOT; i++)
            if (tbl[i].live && r.addr >= tbl[i].start &&
                {1'b0, r.addr} < {1'b0, tbl[i].start} + tbl[i].length) begin
                pg = {r.addr[31:12], 12'h000};
                if (tbl[i].pages != PAGES_MAX) tbl[i].pages++;
                o = entry_beat(i);
                o.page_offset = (pg >= tbl[i].start) ? 31'(pg - tbl[i].start) : '0;
                o.last        = 1'b1;
                pending.push_back(o);
                n_fault_ok++;
                return;
            end
        pending.push_back(err_beat(ST_NOT_MAPPED));
    endfunction

    function void predict_list();
        t_out o;
        int   n;
        n = 0;
        for (int i = 0; i < NSLOT && n < MAX_LIST; i++)
            if (tbl[i].live) begin
                o = entry_beat(i);
                o.entry_valid = 1'b1;
                pending.push_back(o);
                n++;
            end
        if (n == 0) pending.push_back(err_beat(ST_OK));
        else        pending[$].last = 1'b1;
    endfunction

    // accepted request beat
    function void note_request(t_in r);
        n_req++;
        case (r.req_type)
            REQ_MAP:   predict_map(r);
            REQ_UNMAP: predict_unmap(r);
            REQ_FAULT: predict_fault(r);
            default:   predict_list();
        endcase
    endfunction

    // accepted result beat
    function void check_result(t_out got);
        t_out want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                     $time, want, got);
            errors++;
        end else begin
            beats_ok++;
        end
    endfunction
endclass

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mrmt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid, o_in_ready;
    t_in  i_in_data;
    logic o_out_valid, i_out_ready;
    t_out o_out_data;
    logic i_cfg_valid, o_cfg_ready;
    t_cfg i_cfg_data;

    region_table_sb table_sb;
    logic           stim_done;

    memory_region_map_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length in cycles: zero or short most of the time, long in a tenth of draws.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(2, 1);
        return $urandom_range(30, 8);
    endfunction

    // Receiver: random stalls, with stall-free stretches.
    initial begin
        int burst;
        i_out_ready = 1'b0;
        burst       = 0;
        forever begin
            @(negedge i_clk);
            if (burst > 0) begin
                burst--;
                i_out_ready <= 1'b1;
            end else if ($urandom_range(99) < 5) begin
                burst = $urandom_range(40, 10);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= (gap_len() == 0);
            end
        end
    end

    // Sample results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) table_sb.check_result(o_out_data);
    end

    // One request beat; the model is updated at acceptance.
    task automatic send_req(t_in r);
        int g;
        g = gap_len();
        repeat (g + 1) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        table_sb.note_request(r);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Drain all expected beats, then let the block settle before config.
    task automatic wait_idle();
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [32:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= '{index: idx, value: val};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        table_sb.write_window(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in mk(t_req k, logic [31:0] a, logic signed [31:0] len,
                               logic [3:0] fl);
        t_in r;
        r.req_type    = k;
        r.addr        = a;
        r.length      = len;
        r.fixed_flag  = fl[3];
        r.shared_flag = fl[2];
        r.anon_flag   = fl[1];
        r.file_ok     = fl[0];
        return r;
    endfunction

    // Random request biased toward the current window and live regions.
    function automatic t_in rand_req();
        t_in         r;
        int          p, s;
        logic [32:0] span;
        r   = '0;
        p   = $urandom_range(99);
        span = table_sb.win_hi - table_sb.win_lo;
        if (p < 45) begin
            r.req_type = REQ_MAP;
            if (span > 33'h1000 && $urandom_range(9) < 8)
                r.addr = table_sb.win_lo[31:0] +
                         {20'($urandom_range(32'(span[32:12] > 64 ? 64 : span[32:12]))),
                          12'h0};
            else
                r.addr = $urandom;
            r.length = ($urandom_range(9) < 8) ? $urandom_range(40000, 1) : $urandom;
            r.fixed_flag  = ($urandom_range(9) != 0);
            r.shared_flag = ($urandom_range(9) != 0);
            r.anon_flag   = 1'($urandom);
            r.file_ok     = ($urandom_range(9) != 0);
            if ($urandom_range(19) == 0) r.addr[11:0] = 12'($urandom);
        end else if (p < 60) begin
            r.req_type = REQ_UNMAP;
            s = $urandom_range(15);
            r.addr = table_sb.tbl[s].live ? table_sb.tbl[s].start : $urandom;
            r.length = $urandom;
            {r.fixed_flag, r.shared_flag, r.anon_flag, r.file_ok} = 4'($urandom);
        end else if (p < 90) begin
            r.req_type = REQ_FAULT;
            s = $urandom_range(15);
            r.addr = table_sb.tbl[s].live ?
                     table_sb.tbl[s].start + $urandom_range(table_sb.tbl[s].length) :
                     $urandom;
            r.length = $urandom;
            {r.fixed_flag, r.shared_flag, r.anon_flag, r.file_ok} = 4'($urandom);
        end else begin
            r = '0;
            r.req_type = REQ_LIST;
            r.addr     = $urandom;
            r.length   = $urandom;
        end
        return r;
    endfunction

    initial begin
        logic [31:0] base;
        stim_done   = 1'b0;
        table_sb    = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (40) @(posedge i_clk);   // allow for any clearing pass
        @(negedge i_clk);

        // Directed: empty list, error statuses, reset window, fills.
        base = 32'h6000_0000;
        send_req(mk(REQ_LIST,  32'hFFFF_FFFF, -1, 4'hF));
        send_req(mk(REQ_MAP,   base, 0, 4'hF));                 // zero length
        send_req(mk(REQ_MAP,   base, 32'sh8000_0000, 4'hF));    // negative length
        send_req(mk(REQ_MAP,   base, 4096, 4'b0111));           // no fixed
        send_req(mk(REQ_MAP,   base, 4096, 4'b1011));           // no shared
        send_req(mk(REQ_MAP,   base + 1, 4096, 4'hF));          // misaligned
        send_req(mk(REQ_MAP,   base - 32'h1000, 4096, 4'hF));   // below window
        send_req(mk(REQ_MAP,   32'h7FFF_F000, 4097, 4'hF));     // rounds past top
        send_req(mk(REQ_MAP,   base, 4096, 4'b1100));           // bad file
        send_req(mk(REQ_MAP,   base, 1, 4'b1101));              // file backed
        send_req(mk(REQ_MAP,   base + 32'h1000, 4097, 4'b1110));// anon
        send_req(mk(REQ_MAP,   base + 32'h1000, 4096, 4'hF));   // overlap
        send_req(mk(REQ_MAP,   32'h7FFF_F000, 4096, 4'hF));     // top page
        send_req(mk(REQ_FAULT, base + 32'h1FFF, 0, 4'h0));      // second page
        send_req(mk(REQ_FAULT, base + 32'h0FFF, 0, 4'h0));
        send_req(mk(REQ_FAULT, 32'h0000_0000, 0, 4'h0));        // not mapped
        send_req(mk(REQ_LIST,  0, 0, 4'h0));
        send_req(mk(REQ_UNMAP, base + 32'h0800, 0, 4'h0));      // misaligned
        send_req(mk(REQ_UNMAP, base + 32'h5000, 0, 4'h0));      // not found
        send_req(mk(REQ_UNMAP, base, 0, 4'h0));                 // writeback
        send_req(mk(REQ_UNMAP, base + 32'h1000, 0, 4'h0));      // anon
        // Fill all free slots, then two more for no slot.
        for (int i = 0; i < 17; i++)
            send_req(mk(REQ_MAP, base + 32'h0010_0000 + i * 32'h1000, 4096, 4'hF));
        send_req(mk(REQ_LIST, 0, 0, 4'h0));
        wait_idle();

        // Window extremes: whole space, then empty window.
        write_cfg(CFG_WLOW,  33'h0);
        write_cfg(CFG_WHIGH, 33'h1_0000_0000);
        for (int i = 0; i < 16; i++) send_req(mk(REQ_UNMAP, table_sb.tbl[i].start, 0, 0));
        send_req(mk(REQ_MAP, 32'h0, 32'sh7FFF_FFFF, 4'hF));
        send_req(mk(REQ_MAP, 32'hFFFF_F000, 4096, 4'b1110));
        send_req(mk(REQ_FAULT, 32'hFFFF_FFFF, 0, 0));
        send_req(mk(REQ_FAULT, 32'h7FFF_FFFE, 0, 0));
        send_req(mk(REQ_LIST, 0, 0, 0));
        wait_idle();
        write_cfg(CFG_WLOW,  33'h0_FFFF_FFFF);
        write_cfg(CFG_WHIGH, 33'h0);
        send_req(mk(REQ_MAP, 32'hFFFF_F000, 1, 4'hF));
        wait_idle();

        // Random phases over several windows.
        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(CFG_WLOW,  {1'b0, $urandom_range(32'hF000, 0) << 16});
            write_cfg(CFG_WHIGH, {1'b0, table_sb.win_lo[31:0]} +
                                 33'($urandom_range(32'h00400000, 32'h00020000)));
            for (int i = 0; i < 15; i++) begin
                send_req(rand_req());
                if (i == 7) wait_idle();   // sender holds until drained
            end
            wait_idle();
        end
        write_cfg(CFG_WLOW,  33'h6000_0000);
        write_cfg(CFG_WHIGH, 33'h8000_0000);
        send_req(mk(REQ_LIST, 0, 0, 0));
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Ran %0d requests: %0d maps placed, %0d faults hit, %0d beats matched.",
                 table_sb.n_req, table_sb.n_map_ok, table_sb.n_fault_ok,
                 table_sb.beats_ok);
        if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Timeout waiting for requests or results");
        $display("Simulation FAILED");
        $finish;
    end
endmodule
